@@ rtl/core/tida_pkg.sv @@
// Shared types, constants and preset contents of the tag association table.
`timescale 1ns / 1ps

package tida_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int CLS_W = 4;
    localparam int FILL_W = 6;
    localparam int PRESET_COUNT = 4;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_REGISTER = 1'b1;

    localparam logic [1:0] ST_LOOKUP = 2'd0;
    localparam logic [1:0] ST_UPDATED = 2'd1;
    localparam logic [1:0] ST_ADDED = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] tag_key;
        logic [CLS_W-1:0] class_value;
    } t_in_word;

    typedef struct packed {
        logic              hit;
        logic [CLS_W-1:0]  class_out;
        logic [1:0]        status;
        logic [FILL_W-1:0] fill_level;
    } t_out_word;

    // Request travelling down the chain, with what it has found so far.
    typedef struct packed {
        logic             valid;
        logic             action;
        logic [KEY_W-1:0] tag_key;
        logic [CLS_W-1:0] class_value;
        logic             found;
        logic [CLS_W-1:0] class_out;
        logic             added;
    } t_probe;

    function automatic logic [KEY_W-1:0] preset_key(input logic [IDX_W-1:0] idx);
        logic [KEY_W-1:0] key;
        case (idx)
            IDX_W'(0): key = 32'h0453_453B;
            IDX_W'(1): key = 32'h045B_2B3B;
            IDX_W'(2): key = 32'h04DA_413B;
            IDX_W'(3): key = 32'h04FF_333B;
            default:   key = '0;
        endcase
        return key;
    endfunction

    function automatic logic [CLS_W-1:0] preset_class(input logic [IDX_W-1:0] idx);
        logic [CLS_W-1:0] cls;
        case (idx)
            IDX_W'(0): cls = 4'd2;
            IDX_W'(1): cls = 4'd8;
            IDX_W'(2): cls = 4'd4;
            IDX_W'(3): cls = 4'd1;
            default:   cls = '0;
        endcase
        return cls;
    endfunction

endpackage

@@ rtl/core/tag_id_association_table_unit.sv @@
// Top level of the tag association table: request chain, fill count and output stage.
`timescale 1ns / 1ps

// Maps 32-bit tags to 4-bit classes in a row of TABLE_DEPTH entry cells. An accepted
// word walks the row one cell per cycle, then its result passes through a pending
// register into the output register. The next word is taken only once that result
// has moved from the pending register into the output register, so a word is not
// accepted while the previous one is in the chain. A finished result may wait in the
// output register while the next word is already being accepted. After reset the
// table holds four preset tags and reports a fill level of four.
module tag_id_association_table_unit
    import tida_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    t_probe           w_probe [TABLE_DEPTH+1];
    t_probe           w_end;
    logic             w_accept;
    logic             w_pend_move;
    logic             r_busy;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_pend_valid;
    t_out_word        r_pend;
    t_out_word        n_pend;
    logic             r_out_valid;
    t_out_word        r_out;

    assign w_accept    = i_valid && !r_busy;
    assign w_pend_move = r_pend_valid && (!r_out_valid || !i_stall);

    always_comb begin
        w_probe[0]             = '0;
        w_probe[0].valid       = w_accept;
        w_probe[0].action      = i_word.action;
        w_probe[0].tag_key     = i_word.tag_key;
        w_probe[0].class_value = i_word.class_value;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        tida_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_count (r_count),
            .i_probe (w_probe[g]),
            .o_probe (w_probe[g+1])
        );
    end

    assign w_end = w_probe[TABLE_DEPTH];

    always_comb begin
        n_count = r_count + CNT_W'(w_end.added);
        n_pend.hit        = w_end.found;
        n_pend.class_out  = w_end.class_out;
        n_pend.fill_level = FILL_W'(n_count);
        if (w_end.action == ACT_LOOKUP) begin
            n_pend.status = ST_LOOKUP;
        end else if (w_end.found) begin
            n_pend.status = ST_UPDATED;
        end else if (w_end.added) begin
            n_pend.status = ST_ADDED;
        end else begin
            n_pend.status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_count      <= CNT_W'(PRESET_COUNT);
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_pend_move) begin
                r_busy <= 1'b0;
            end
            if (w_end.valid) begin
                r_count      <= n_count;
                r_pend_valid <= 1'b1;
            end else if (w_pend_move) begin
                r_pend_valid <= 1'b0;
            end
            if (w_pend_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end.valid) begin
            r_pend <= n_pend;
        end
        if (w_pend_move) begin
            r_out <= r_pend;
        end
    end

    assign o_stall = r_busy;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_busy)
        else $error("pending result without a word in flight");

    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.valid |-> (r_busy && !r_pend_valid))
        else $error("chain end reached with no word in flight or result slot taken");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_end.valid && w_end.added) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("fill count not advanced on append");
`endif

endmodule

@@ rtl/core/tida_cell.sv @@
// One table entry: compares, updates or appends as a request passes through.
`timescale 1ns / 1ps

module tida_cell
    import tida_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  logic [CNT_W-1:0] i_count,
    input  t_probe           i_probe,
    output t_probe           o_probe
);

    logic [KEY_W-1:0] r_key;
    logic [CLS_W-1:0] r_class;
    t_probe           r_probe;
    t_probe           n_probe;
    logic             w_filled;
    logic             w_match;
    logic             w_append;

    assign w_filled = CNT_W'(i_index) < i_count;
    assign w_match  = i_probe.valid && !i_probe.found && w_filled && (r_key == i_probe.tag_key);
    // The first empty slot is this cell when its index equals the fill count.
    assign w_append = i_probe.valid && !i_probe.found && (i_probe.action == ACT_REGISTER)
                      && (CNT_W'(i_index) == i_count);

    always_comb begin
        n_probe = i_probe;
        if (w_match) begin
            n_probe.found = 1'b1;
            if (i_probe.action == ACT_LOOKUP) begin
                n_probe.class_out = r_class;
            end
        end
        if (w_append) begin
            n_probe.added = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= preset_key(i_index);
            r_class <= preset_class(i_index);
        end else if (w_append) begin
            r_key   <= i_probe.tag_key;
            r_class <= i_probe.class_value;
        end else if (w_match && i_probe.action == ACT_REGISTER) begin
            r_class <= i_probe.class_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe.valid;
        end
        r_probe.action      <= n_probe.action;
        r_probe.tag_key     <= n_probe.tag_key;
        r_probe.class_value <= n_probe.class_value;
        r_probe.found       <= n_probe.found;
        r_probe.class_out   <= n_probe.class_out;
        r_probe.added       <= n_probe.added;
    end

    assign o_probe = r_probe;

endmodule

@@ sim/tag_id_association_table_unit_tb.sv @@
// Self-checking testbench for the tag association table with random flow control on both sides.
`timescale 1ns / 1ps

module tag_id_association_table_unit_tb;
    import tida_pkg::*;

    localparam int RANDOM_ITEMS = 1436;
    localparam int TAIL_ITEMS = 120;
    localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 3);
    localparam int CYCLE_LIMIT = (RANDOM_ITEMS + 40) * (TABLE_DEPTH + 3 + 32) * 4 + 10000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_word = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_word;

    tag_id_association_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the table contents, updated in acceptance order.
    logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
    logic [CLS_W-1:0] shadow_classes [TABLE_DEPTH];
    int               shadow_count;

    t_in_word         tag_requests [$];
    t_out_word        replies_due [$];
    logic [KEY_W-1:0] known_tags [$];

    logic word_taken = 1'b0;
    int   n_total = 0;
    int   n_accepted = 0;
    int   n_checked = 0;
    int   n_fail = 0;
    int   send_gap = 0;
    int   stall_gap = 0;
    int   cycle_cnt = 0;
    int   n_hits = 0;
    int   n_misses = 0;
    int   n_updates = 0;
    int   n_adds = 0;
    int   n_refused = 0;

    function automatic bit in_tail();
        return tag_requests.size() < TAIL_ITEMS;
    endfunction

    // Applies one request to the shadow table and returns the reply it must produce.
    function automatic t_out_word tag_table_apply(input t_in_word req);
        t_out_word reply;
        int        slot;
        bit        found;
        found = 1'b0;
        slot = 0;
        for (int k = 0; k < shadow_count && k < TABLE_DEPTH; k++) begin
            if (!found && shadow_keys[k] == req.tag_key) begin
                found = 1'b1;
                slot = k;
            end
        end
        reply = '0;
        reply.hit = found;
        if (req.action == ACT_LOOKUP) begin
            reply.status = ST_LOOKUP;
            if (found) begin
                reply.class_out = shadow_classes[slot];
                n_hits++;
            end else begin
                n_misses++;
            end
        end else if (found) begin
            shadow_classes[slot] = req.class_value;
            reply.status = ST_UPDATED;
            n_updates++;
        end else if (shadow_count < TABLE_DEPTH) begin
            shadow_keys[shadow_count] = req.tag_key;
            shadow_classes[shadow_count] = req.class_value;
            shadow_count++;
            reply.status = ST_ADDED;
            n_adds++;
        end else begin
            reply.status = ST_FULL;
            n_refused++;
        end
        reply.fill_level = FILL_W'(shadow_count);
        return reply;
    endfunction

    task automatic queue_request(input logic act, input logic [KEY_W-1:0] key,
                                 input logic [CLS_W-1:0] cls);
        t_in_word req;
        req.action = act;
        req.tag_key = key;
        req.class_value = cls;
        tag_requests.push_back(req);
        if (act == ACT_REGISTER) begin
            known_tags.push_back(key);
        end
    endtask

    // Sender: holds a word while stalled, otherwise idles in bursts or presents the next word.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !word_taken) begin
            i_valid <= 1'b1;
        end else if (send_gap > 0) begin
            i_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (tag_requests.size() > 0 && !in_tail() && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            send_gap <= $urandom_range(0, 15);
        end else if (tag_requests.size() > 0) begin
            i_valid <= 1'b1;
            i_word <= tag_requests.pop_front();
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (stall_gap > 0) begin
            i_stall <= 1'b1;
            stall_gap <= stall_gap - 1;
        end else if (i_rst_n && !in_tail() && $urandom_range(0, 9) == 0) begin
            i_stall <= 1'b1;
            stall_gap <= $urandom_range(0, 15);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_out_word due;
        t_out_word seen;
        word_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = o_word;
            n_checked++;
            if (replies_due.size() == 0) begin
                $error("unexpected reply word: hit %0d class %0d status %0d fill %0d",
                       seen.hit, seen.class_out, seen.status, seen.fill_level);
                n_fail++;
            end else begin
                due = replies_due.pop_front();
                if (seen.hit !== due.hit) begin
                    $error("hit: expected %0d, got %0d", due.hit, seen.hit);
                    n_fail++;
                end
                if (seen.class_out !== due.class_out) begin
                    $error("class_out: expected %0d, got %0d", due.class_out, seen.class_out);
                    n_fail++;
                end
                if (seen.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, seen.status);
                    n_fail++;
                end
                if (seen.fill_level !== due.fill_level) begin
                    $error("fill_level: expected %0d, got %0d", due.fill_level,
                           seen.fill_level);
                    n_fail++;
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            replies_due.push_back(tag_table_apply(i_word));
            n_accepted++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tag_id_association_table_unit_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int               pick;
        logic [KEY_W-1:0] key;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            shadow_keys[k] = '0;
            shadow_classes[k] = '0;
        end
        shadow_keys[0] = 32'h0453_453B;
        shadow_keys[1] = 32'h045B_2B3B;
        shadow_keys[2] = 32'h04DA_413B;
        shadow_keys[3] = 32'h04FF_333B;
        shadow_classes[0] = 4'd2;
        shadow_classes[1] = 4'd8;
        shadow_classes[2] = 4'd4;
        shadow_classes[3] = 4'd1;
        shadow_count = PRESET_COUNT;
        for (int k = 0; k < PRESET_COUNT; k++) begin
            known_tags.push_back(shadow_keys[k]);
        end

        // Preset tags hit with their stored classes; the class field is ignored on lookup.
        queue_request(ACT_LOOKUP, 32'h0453_453B, 4'hF);
        queue_request(ACT_LOOKUP, 32'h045B_2B3B, 4'h0);
        queue_request(ACT_LOOKUP, 32'h04DA_413B, 4'h5);
        queue_request(ACT_LOOKUP, 32'h04FF_333B, 4'hA);
        // All-zero and all-one keys miss, even though unused entries may hold zero.
        queue_request(ACT_LOOKUP, 32'h0000_0000, 4'h0);
        queue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 4'hF);
        queue_request(ACT_LOOKUP, 32'h0453_453A, 4'h3);
        queue_request(ACT_REGISTER, 32'h0453_453B, 4'h0);
        queue_request(ACT_LOOKUP, 32'h0453_453B, 4'h9);
        queue_request(ACT_REGISTER, 32'h0000_0000, 4'hF);
        queue_request(ACT_REGISTER, 32'hFFFF_FFFF, 4'h7);
        queue_request(ACT_LOOKUP, 32'h0000_0000, 4'h0);
        queue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 4'h0);
        queue_request(ACT_REGISTER, 32'hFFFF_FFFF, 4'hA);
        queue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 4'h1);
        queue_request(ACT_REGISTER, 32'h04FF_333B, 4'hF);

        // Mostly known tags with random classes; fresh tags fill the table and then get refused.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                key = known_tags[$urandom_range(0, known_tags.size() - 1)];
            end else if (pick < 65) begin
                key = known_tags[$urandom_range(0, known_tags.size() - 1)]
                      ^ (32'h1 << $urandom_range(0, 31));
            end else begin
                key = $urandom();
            end
            queue_request($urandom_range(0, 1) ? ACT_REGISTER : ACT_LOOKUP, key,
                          CLS_W'($urandom_range(0, 15)));
        end
        n_total = tag_requests.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || replies_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d replies for %0d requests: %0d lookup hits, %0d lookup misses.",
                 n_checked, n_total, n_hits, n_misses);
        $display("Registers: %0d updates, %0d new entries, %0d refused on a full table.",
                 n_updates, n_adds, n_refused);
        if (n_fail == 0) begin
            $display("tag_id_association_table_unit_tb: PASS");
        end else begin
            $display("tag_id_association_table_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
